@@ rtl/core/rxd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rxd_pkg: shared types and constants of the run-length / XOR delta decoder
// Configuration codes, command and status bundles, palette lookup.
// ---------------------------------------------------------------------------
package rxd_pkg;

  localparam int CFG_W        = 10;  // widest configuration register
  localparam int CFG_ADDR_W   = 2;
  localparam int DIM_W        = 10;  // image_width / image_height
  localparam int COLOR_W      = 4;
  localparam int BYTE_W       = 8;
  localparam int HDR_W        = 2;
  localparam int RUN_W        = 8;
  localparam int PIX_W        = 32;
  localparam int CNT_W        = 3;
  localparam int PIX_PER_BEAT = 4;
  localparam int OUT_TDATA_W  = 136; // 4 x 32 + 3, padded to whole bytes

  // A byte above this value after a pending color is a run count.
  localparam logic [BYTE_W-1:0] RUN_THRESH = 8'h0F;
  localparam logic [BYTE_W-1:0] RUN_BIAS   = 8'h0E;
  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WIDTH        = 2'd0,
    CFG_HEIGHT       = 2'd1,
    CFG_TRANSP_EN    = 2'd2,
    CFG_TRANSP_COLOR = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic               transp_en;
    logic [COLOR_W-1:0] transp_color;
  } rxd_cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic               restart;
    logic               pix_valid;
    logic [COLOR_W-1:0] pix_color;
    logic               pix_last;
  } rxd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ready;  // a pixel request can be taken this cycle
    logic done;   // image finished
    logic halt;   // no pixel will be written (done or zero size)
  } rxd_status_t;

  function automatic logic [PIX_W-1:0] palette_rgba(input logic [COLOR_W-1:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hd43a48;
      4'd2:    rgb = 24'h916721;
      4'd3:    rgb = 24'he66f00;
      4'd4:    rgb = 24'h398238;
      4'd5:    rgb = 24'h686868;
      4'd6:    rgb = 24'h67df42;
      4'd7:    rgb = 24'hffff00;
      4'd8:    rgb = 24'h0c1ca2;
      4'd9:    rgb = 24'he628ff;
      4'd10:   rgb = 24'hb8b8b8;
      4'd11:   rgb = 24'hf3b3a2;
      4'd12:   rgb = 24'h2f3ee5;
      4'd13:   rgb = 24'h79a6de;
      4'd14:   rgb = 24'h58f4bf;
      default: rgb = 24'hffffff;
    endcase
    return {rgb, ALPHA_OPAQUE};
  endfunction

endpackage

@@ rtl/core/rxd_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rxd_ram: generic simple dual-port RAM
// One write port, one read port with registered data (old data on collision).
// ---------------------------------------------------------------------------
module rxd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/rxd_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rxd_ctrl: byte parser and pixel sequencer
// Skip header, track the pending color, expand runs into pixel requests.
// ---------------------------------------------------------------------------
module rxd_ctrl #(
  parameter int HEADER_BYTES = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [rxd_pkg::BYTE_W-1:0]  byte_data,
  input  logic                        byte_first,
  input  logic                        byte_last,
  output rxd_pkg::rxd_cmd_t           cmd,
  input  rxd_pkg::rxd_status_t        status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [rxd_pkg::HDR_W-1:0] HDR_INIT = rxd_pkg::HDR_W'(HEADER_BYTES);

  state_t                         state_r, state_nxt;
  logic [rxd_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  logic [rxd_pkg::COLOR_W-1:0]    pend_c_r, pend_c_nxt;
  logic                           pend_v_r, pend_v_nxt;
  logic [rxd_pkg::COLOR_W-1:0]    run_c_r, run_c_nxt;
  logic [rxd_pkg::RUN_W-1:0]      run_left_r, run_left_nxt;
  logic [rxd_pkg::COLOR_W-1:0]    tail_c_r, tail_c_nxt;
  logic                           tail_v_r, tail_v_nxt;

  logic                           accept;
  logic [rxd_pkg::HDR_W-1:0]      hdr_eff;
  logic [rxd_pkg::COLOR_W-1:0]    pend_c_eff;
  logic                           pend_v_eff;
  logic                           done_eff;
  logic                           cur_last;
  logic                           fire;

  assign byte_ready = (state_r == ST_IDLE);
  assign accept     = byte_valid && byte_ready;

  // A first byte restarts the image before it is parsed.
  assign hdr_eff    = byte_first ? HDR_INIT : hdr_r;
  assign pend_c_eff = byte_first ? '0 : pend_c_r;
  assign pend_v_eff = byte_first ? 1'b0 : pend_v_r;
  assign done_eff   = byte_first ? 1'b0 : status.done;

  assign cur_last = (run_left_r == '0) || ((run_left_r == rxd_pkg::RUN_W'(1)) && !tail_v_r);
  assign fire     = (state_r == ST_RUN) && !status.halt && status.ready;

  always_comb begin
    cmd.restart   = accept && byte_first;
    cmd.pix_valid = (state_r == ST_RUN) && !status.halt;
    cmd.pix_color = (run_left_r != '0) ? run_c_r : tail_c_r;
    cmd.pix_last  = cur_last;
  end

  always_comb begin
    state_nxt    = state_r;
    hdr_nxt      = hdr_r;
    pend_c_nxt   = pend_c_r;
    pend_v_nxt   = pend_v_r;
    run_c_nxt    = run_c_r;
    run_left_nxt = run_left_r;
    tail_c_nxt   = tail_c_r;
    tail_v_nxt   = tail_v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hdr_nxt    = hdr_eff;
          pend_c_nxt = pend_c_eff;
          pend_v_nxt = pend_v_eff;
          if (hdr_eff != '0) begin
            hdr_nxt = hdr_eff - rxd_pkg::HDR_W'(1);
          end else if (!done_eff) begin
            run_c_nxt = pend_c_eff;
            if (pend_v_eff && (byte_data > rxd_pkg::RUN_THRESH)) begin
              run_left_nxt = byte_data - rxd_pkg::RUN_BIAS;
              tail_v_nxt   = 1'b0;
              pend_v_nxt   = 1'b0;
            end else begin
              run_left_nxt = pend_v_eff ? rxd_pkg::RUN_W'(1) : '0;
              pend_c_nxt   = byte_data[rxd_pkg::COLOR_W-1:0];
              tail_c_nxt   = byte_data[rxd_pkg::COLOR_W-1:0];
              // last flushes the new color right away
              tail_v_nxt   = byte_last;
              pend_v_nxt   = !byte_last;
            end
            if ((pend_v_eff) || byte_last) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (status.halt) begin
          // drop the rest of the run
          state_nxt = ST_IDLE;
        end else if (fire) begin
          if (run_left_r != '0) begin
            run_left_nxt = run_left_r - rxd_pkg::RUN_W'(1);
          end else begin
            tail_v_nxt = 1'b0;
          end
          if (cur_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      hdr_r      <= HDR_INIT;
      pend_c_r   <= '0;
      pend_v_r   <= 1'b0;
      run_left_r <= '0;
      tail_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hdr_r      <= hdr_nxt;
      pend_c_r   <= pend_c_nxt;
      pend_v_r   <= pend_v_nxt;
      run_left_r <= run_left_nxt;
      tail_v_r   <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_c_r  <= run_c_nxt;
    tail_c_r <= tail_c_nxt;
  end

endmodule

@@ rtl/core/rxd_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rxd_datapath: raster counters, line store, XOR delta, palette, packing
// Two stages: read the pixel above, then reconstruct, map and pack by four.
// ---------------------------------------------------------------------------
module rxd_datapath #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rxd_pkg::rxd_cfg_t                 cfg,
  input  rxd_pkg::rxd_cmd_t                 cmd,
  output rxd_pkg::rxd_status_t              status,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rxd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > rxd_pkg::DIM_W) ?
                         $clog2(MAX_WIDTH + 1) : rxd_pkg::DIM_W;
  localparam int HD_W  = ($clog2(MAX_HEIGHT + 1) > rxd_pkg::DIM_W) ?
                         $clog2(MAX_HEIGHT + 1) : rxd_pkg::DIM_W;
  localparam int CW    = rxd_pkg::COLOR_W;
  localparam int PW    = rxd_pkg::PIX_W;

  // effective image size
  logic [WD_W-1:0] w_ext, w_eff, col_inc;
  logic [HD_W-1:0] h_ext, h_eff, row_inc;
  logic            halt;
  logic            wrap_col, wrap_row;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;

  // stage 1
  logic             s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_xor_r;
  logic [CW-1:0]    s1_color_r;
  logic             s1_last_r;
  logic             s1_final_r;
  logic             s1_go, s1_adv;
  logic             pix_take;

  // write forwarding for back-to-back access to one column
  logic [COL_W-1:0] fw_addr_r;
  logic [CW-1:0]    fw_val_r;
  logic             fw_v_r;

  logic [CW-1:0]    ram_q;
  logic [CW-1:0]    above;
  logic [CW-1:0]    recon;
  logic [PW-1:0]    rgba;

  // packer
  logic [PW-1:0]    acc_r [3];
  logic [1:0]       acc_cnt_r, acc_cnt_nxt;
  logic             closes;
  logic             out_valid_r, out_valid_nxt;
  logic [PW-1:0]    out_pix_r [rxd_pkg::PIX_PER_BEAT];
  logic [rxd_pkg::CNT_W-1:0] out_cnt_r;
  logic             out_last_r;
  logic             out_final_r;

  assign w_ext   = WD_W'(cfg.width);
  assign h_ext   = HD_W'(cfg.height);
  assign w_eff   = (w_ext > WD_W'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) : w_ext;
  assign h_eff   = (h_ext > HD_W'(MAX_HEIGHT)) ? HD_W'(MAX_HEIGHT) : h_ext;
  assign halt    = done_r || (w_eff == '0) || (h_eff == '0);
  assign col_inc = WD_W'(col_r) + WD_W'(1);
  assign row_inc = HD_W'(row_r) + HD_W'(1);
  assign wrap_col = (col_inc >= w_eff);
  assign wrap_row = (row_inc >= h_eff);

  assign closes = s1_last_r || (acc_cnt_r == 2'd3);
  assign s1_go  = s1_valid_r && (!closes || !out_valid_r || out_tready);
  assign s1_adv = !s1_valid_r || s1_go;
  assign pix_take = cmd.pix_valid && s1_adv && !halt;

  always_comb begin
    status.ready = s1_adv;
    status.done  = done_r;
    status.halt  = halt;
  end

  // raster position advances at read issue
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (cmd.restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      done_nxt = 1'b0;
    end else if (pix_take) begin
      if (wrap_col) begin
        col_nxt = '0;
        if (wrap_row) begin
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  assign s1_valid_nxt = s1_adv ? pix_take : s1_valid_r;

  rxd_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (recon),
    .re    (pix_take),
    .raddr (col_r),
    .rdata (ram_q)
  );

  assign above = (fw_v_r && (fw_addr_r == s1_col_r)) ? fw_val_r : ram_q;
  assign recon = s1_xor_r ? (s1_color_r ^ above) : s1_color_r;
  assign rgba  = (cfg.transp_en && (cfg.transp_color == recon)) ? '0 :
                 rxd_pkg::palette_rgba(recon);

  assign acc_cnt_nxt   = !s1_go ? acc_cnt_r : (closes ? 2'd0 : acc_cnt_r + 2'd1);
  assign out_valid_nxt = (s1_go && closes) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      done_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      fw_v_r      <= 1'b0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      done_r      <= done_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fw_v_r      <= fw_v_r || s1_go;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_col_r   <= col_r;
      s1_xor_r   <= (row_r != '0);
      s1_color_r <= cmd.pix_color;
      // the image's final pixel also ends the byte's results
      s1_last_r  <= cmd.pix_last || (wrap_col && wrap_row);
      s1_final_r <= wrap_col && wrap_row;
    end
    if (s1_go) begin
      fw_addr_r <= s1_col_r;
      fw_val_r  <= recon;
      if (!closes) begin
        acc_r[acc_cnt_r] <= rgba;
      end else begin
        for (int j = 0; j < rxd_pkg::PIX_PER_BEAT; j++) begin
          if (j < int'(acc_cnt_r)) begin
            out_pix_r[j] <= acc_r[j % 3];
          end else if (j == int'(acc_cnt_r)) begin
            out_pix_r[j] <= rgba;
          end else begin
            out_pix_r[j] <= '0;
          end
        end
        out_cnt_r   <= rxd_pkg::CNT_W'(acc_cnt_r) + rxd_pkg::CNT_W'(1);
        out_last_r  <= s1_last_r;
        out_final_r <= s1_final_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_pix_r[3], out_pix_r[2],
                       out_pix_r[1], out_pix_r[0]};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_final_r;

endmodule

@@ rtl/core/rle_xor_delta_palette_decoder.sv @@
`timescale 1ns / 1ps
// A byte with pixels to issue moves the parser to its run state, from which they issue;
//   a result reaches out_tvalid through the line store read register, then the map and
//   output register. Throughput: one pixel per cycle (single line store read port) while
//   the output register is not stalled by out_tready; the input is held while a byte's
//   run expands, so a new byte is taken only once the last pixel of that byte issues.
// Reset: synchronous, active low; clears parser, counters and output valid, not the line store.
// ---------------------------------------------------------------------------
// rle_xor_delta_palette_decoder: run-length image decoder with vertical XOR
// Expands RLE bytes to 4-bit pixels, undoes the row delta, maps to RGBA.
// ---------------------------------------------------------------------------
module rle_xor_delta_palette_decoder #(
  parameter int MAX_WIDTH    = 512,
  parameter int MAX_HEIGHT   = 512,
  parameter int HEADER_BYTES = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input byte stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rxd_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] compressed_byte
  input  logic                                in_tlast,   // last_byte
  input  logic                                in_tuser,   // [0] first_byte
  // pixel result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rxd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] pixel_a,
                                                          // [63:32] pixel_b,
                                                          // [95:64] pixel_c,
                                                          // [127:96] pixel_d,
                                                          // [130:128] valid_count,
                                                          // [135:131] zero
  output logic                                out_tlast,  // last_of_run
  output logic                                out_tuser,  // [0] image_complete
  // configuration writes
  input  logic                                cfg_we,
  input  logic [rxd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rxd_pkg::CFG_W-1:0]           cfg_wdata
);

  rxd_pkg::rxd_cfg_t    cfg_r, cfg_nxt;
  rxd_pkg::rxd_cmd_t    cmd;
  rxd_pkg::rxd_status_t status;

  // Configuration register file. The user writes it only while the decoder is idle (not
  // enforced here), so the datapath sees a stable size and palette setup for the whole image.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        rxd_pkg::CFG_WIDTH:        cfg_nxt.width        = cfg_wdata[rxd_pkg::DIM_W-1:0];
        rxd_pkg::CFG_HEIGHT:       cfg_nxt.height       = cfg_wdata[rxd_pkg::DIM_W-1:0];
        rxd_pkg::CFG_TRANSP_EN:    cfg_nxt.transp_en    = cfg_wdata[0];
        rxd_pkg::CFG_TRANSP_COLOR: cfg_nxt.transp_color =
                                     cfg_wdata[rxd_pkg::COLOR_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width        <= rxd_pkg::DIM_W'(1);
      cfg_r.height       <= rxd_pkg::DIM_W'(1);
      cfg_r.transp_en    <= 1'b0;
      cfg_r.transp_color <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Controller: parse header, pending color and run counts; issue one pixel
  // request per cycle while the datapath is ready and hold the input while a run expands.
  rxd_ctrl #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .byte_data  (in_tdata),
    .byte_first (in_tuser),
    .byte_last  (in_tlast),
    .cmd        (cmd),
    .status     (status)
  );

  // Datapath: raster counters, line store with write forwarding, XOR with the
  // row above, palette and transparency, packing by four into the output register.
  rxd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the RLE / vertical XOR palette decoder
// Streams short compressed images through the byte port, mirrors the
// decoding in a scoreboard (runs, row delta, palette, transparency) and
// compares every pixel result field by field, under random back-pressure.
// ---------------------------------------------------------------------------
module tb_top;
  import rxd_pkg::*;

  localparam int HEADER_BYTES     = 3;
  localparam int MAX_W            = 512;
  localparam int MAX_H            = 512;
  localparam int RANDOM_BYTES     = 300;
  localparam int CALM_TAIL        = 50;       // phases begun within the last bytes run with no idling
  localparam int SETTLE_CYCLES    = 16;       // a header or empty byte may still be in flight
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int MAX_REPORTS      = 100;

  localparam logic [23:0] PALETTE [16] = '{
    24'h000000, 24'hd43a48, 24'h916721, 24'he66f00,
    24'h398238, 24'h686868, 24'h67df42, 24'hffff00,
    24'h0c1ca2, 24'he628ff, 24'hb8b8b8, 24'hf3b3a2,
    24'h2f3ee5, 24'h79a6de, 24'h58f4bf, 24'hffffff
  };

  // One output request: up to four RGBA pixels, pix[0] is pixel_a.
  typedef struct packed {
    logic [3:0][PIX_W-1:0] pix;
    logic [CNT_W-1:0]      count;
    logic                  run_end;
    logic                  img_end;
  } pixel_beat_t;

  // Mirrors the decoder state and queues the results each byte causes.
  class pixel_scoreboard;
    logic [DIM_W-1:0]   width_reg    = 10'd1;
    logic [DIM_W-1:0]   height_reg   = 10'd1;
    logic               transp_en    = 1'b0;
    logic [COLOR_W-1:0] transp_color = '0;

    logic [COLOR_W-1:0] row_above [MAX_W];
    logic [COLOR_W-1:0] held_color;
    bit                 held_valid;
    int                 header_left;
    int                 col;
    int                 row;
    bit                 done;

    logic [PIX_W-1:0]   run_pixels [$];
    pixel_beat_t        beats_due [$];
    int                 errors, bytes_used, beats_seen, pixels_seen, images_done;

    function new();
      restart();
    endfunction

    function void restart();
      held_color  = '0;
      held_valid  = 1'b0;
      header_left = HEADER_BYTES;
      col         = 0;
      row         = 0;
      done        = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WIDTH:        width_reg    = val;
        CFG_HEIGHT:       height_reg   = val;
        CFG_TRANSP_EN:    transp_en    = val[0];
        CFG_TRANSP_COLOR: transp_color = val[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] rgba(logic [COLOR_W-1:0] idx);
      if (transp_en && idx == transp_color) return '0;
      return {PALETTE[idx], 8'hFF};
    endfunction

    // Undo the row delta, remember the pixel for the next row, advance raster.
    function void emit_pixel(logic [COLOR_W-1:0] raw);
      int w, h;
      logic [COLOR_W-1:0] c;
      w = (width_reg > MAX_W) ? MAX_W : int'(width_reg);
      h = (height_reg > MAX_H) ? MAX_H : int'(height_reg);
      if (done || w == 0 || h == 0) return;
      c = raw;
      if (col < MAX_W) begin
        if (row > 0) c ^= row_above[col];
        row_above[col] = c;
      end
      run_pixels.push_back(rgba(c));
      if (col + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) done = 1'b1;
        else row++;
      end else begin
        col++;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic first, logic lst);
      bit          was_done;
      int          n, k, j;
      pixel_beat_t beat;
      if (first) restart();
      was_done = done;
      if (!was_done) bytes_used++;
      run_pixels.delete();
      if (header_left > 0) begin
        header_left--;
      end else if (!done) begin
        if (held_valid && b > RUN_THRESH) begin
          repeat (int'(b - RUN_BIAS)) emit_pixel(held_color);
          held_valid = 1'b0;
        end else begin
          if (held_valid) emit_pixel(held_color);
          held_color = b[COLOR_W-1:0];
          held_valid = 1'b1;
        end
        if (lst && held_valid) begin
          emit_pixel(held_color);
          held_valid = 1'b0;
        end
      end
      n = run_pixels.size();
      for (k = 0; k < n; k += PIX_PER_BEAT) begin
        beat = '0;
        for (j = 0; j < PIX_PER_BEAT && k + j < n; j++) beat.pix[j] = run_pixels[k + j];
        beat.count   = CNT_W'((n - k > PIX_PER_BEAT) ? PIX_PER_BEAT : n - k);
        beat.run_end = (k + PIX_PER_BEAT >= n);
        beat.img_end = beat.run_end && done && !was_done;
        beats_due.push_back(beat);
      end
      if (done && !was_done) images_done++;
    endfunction

    function void report(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] data, logic lst, logic usr);
      pixel_beat_t want;
      int j;
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
                   $time, data, lst, usr);
        return;
      end
      want = beats_due.pop_front();
      beats_seen++;
      pixels_seen += int'(want.count);
      for (j = 0; j < PIX_PER_BEAT; j++)
        if (data[PIX_W*j +: PIX_W] !== want.pix[j])
          report($sformatf("pixel %0d", j), want.pix[j], data[PIX_W*j +: PIX_W]);
      if (data[PIX_W*PIX_PER_BEAT +: CNT_W] !== want.count)
        report("valid_count", PIX_W'(want.count), PIX_W'(data[PIX_W*PIX_PER_BEAT +: CNT_W]));
      if (lst !== want.run_end) report("last_of_run", PIX_W'(want.run_end), PIX_W'(lst));
      if (usr !== want.img_end) report("image_complete", PIX_W'(want.img_end), PIX_W'(usr));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;
  logic                   in_tlast;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;

  pixel_scoreboard sb;
  int  in_idle_pct  = 0;    // chance per request that an idle burst follows
  int  out_idle_pct = 0;    // chance per cycle that a stall burst starts
  bit  long_hold    = 1'b0; // ask the receiver for one long stall
  int  cycle_count  = 0;

  rle_xor_delta_palette_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               sb.beats_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sample accepted results at the rising edge, before the DUT updates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast, out_tuser);
  end

  // Receiver back-pressure: short random stall bursts, or one long hold on request.
  initial begin : ready_gen
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        stall     = LONG_HOLD_CYCLES;
      end else if (stall == 0 && out_idle_pct != 0 &&
                   $urandom_range(1, 100) <= out_idle_pct) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Offer one byte request; hold it until the decoder takes it, then maybe idle.
  task automatic send_byte(logic [BYTE_W-1:0] b, logic first, logic lst);
    @(negedge clk);
    in_tdata  = b;
    in_tuser  = first;
    in_tlast  = lst;
    in_tvalid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    sb.take_byte(b, first, lst);
    if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_cfg(int w, int h, bit te, int tc);
    write_reg(CFG_WIDTH, CFG_W'(w));
    write_reg(CFG_HEIGHT, CFG_W'(h));
    write_reg(CFG_TRANSP_EN, CFG_W'(te));
    write_reg(CFG_TRANSP_COLOR, CFG_W'(tc));
  endtask

  // Mostly colors and run counts, some arbitrary bytes.
  function automatic logic [BYTE_W-1:0] pick_data_byte(bit long_runs);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return BYTE_W'($urandom_range(0, 15));
    if (r < 85) return long_runs ? BYTE_W'($urandom_range(8'hC0, 8'hFF))
                                 : BYTE_W'($urandom_range(8'h10, 8'h2F));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_header();
    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 19) == 0);
    repeat (HEADER_BYTES - 1)
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 19) == 0);
  endtask

  // Data bytes until the image completes or the budget runs out; a stray
  // restart now and then breaks the sequence. Trailing bytes after a
  // finished image are ignored by the decoder.
  task automatic send_body(int budget, bit long_runs);
    int   k;
    logic lst;
    logic first;
    for (k = 0; k < budget && !sb.done; k++) begin
      lst   = (k == budget - 1) || ($urandom_range(0, 24) == 0);
      first = ($urandom_range(0, 59) == 0);
      send_byte(pick_data_byte(long_runs), first, lst);
    end
    if (sb.done)
      repeat ($urandom_range(0, 2))
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_image(int budget, bit long_runs);
    send_header();
    send_body(budget, long_runs);
  endtask

  function automatic int pick_color();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 0;
    if (r == 1) return 15;
    return $urandom_range(0, 15);
  endfunction

  initial begin : stimulus
    int target, phase, n_img;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_WIDTH;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: 4x2 image, transparent color 5.
    write_cfg(4, 2, 1'b1, 5);
    send_byte(8'hA5, 1'b1, 1'b0);       // header, extreme values
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);       // color 0 held
    send_byte(8'h0F, 1'b0, 1'b0);       // emit 0, hold 15
    send_byte(8'h10, 1'b0, 1'b0);       // run of two
    send_byte(8'hF5, 1'b0, 1'b0);       // high byte with nothing held is a color
    send_byte(8'h03, 1'b0, 1'b1);       // emit 5 (transparent), flush 3 on last
    send_byte(8'h1C, 1'b0, 1'b0);       // continue the same image after last
    send_byte(8'hFF, 1'b0, 1'b0);       // long run, cut off at image end
    send_byte(8'h42, 1'b0, 1'b1);       // ignored, image done
    send_byte(8'h77, 1'b1, 1'b1);       // last flag on a header byte
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h09, 1'b0, 1'b1);       // single pixel by flush
    // Zero width: no pixels at all.
    wait_drained();
    write_cfg(0, 3, 1'b0, 15);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h11, 1'b0, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h06, 1'b0, 1'b0);
    send_byte(8'h30, 1'b0, 1'b1);
    // Oversize width saturates to the line store depth.
    wait_drained();
    write_cfg(1023, 1, 1'b0, 0);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'h0A, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h0B, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h0C, 1'b0, 1'b0);
    send_byte(8'h2C, 1'b0, 1'b1);       // completes 512 pixels exactly

    // Random phases: reconfigure while idle, then stream images.
    target = sb.bytes_used + RANDOM_BYTES;
    phase  = 0;
    while (sb.bytes_used < target) begin
      wait_drained();
      in_idle_pct  = (phase % 4 == 3) ? 0 : 10 * $urandom_range(1, 4);
      out_idle_pct = (phase % 5 == 4) ? 0 : 4 * $urandom_range(1, 4);
      if (sb.bytes_used > target - CALM_TAIL) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (phase)
        0: begin                        // zero height
          write_cfg($urandom_range(1, 16), 0, 1'b1, pick_color());
          send_image(6, 1'b0);
        end
        1: begin                        // oversize height on a single column
          write_cfg(1, 1023, 1'b0, pick_color());
          send_image(20, 1'b1);
        end
        2: begin                        // full-depth rows, second row reads back
          write_cfg(1023, 1023, 1'b1, 15);
          send_image(12, 1'b1);
        end
        3: begin
          write_cfg(512, 2, 1'b0, 0);
          send_image(16, 1'b1);
        end
        4: begin
          write_cfg(1, 1, 1'b1, pick_color());
          repeat (3) send_image(3, 1'b0);
        end
        5: begin                        // shrink the frame mid-image
          write_cfg(12, 4, 1'b1, pick_color());
          send_image(8, 1'b0);
          wait_drained();
          write_reg(CFG_WIDTH, CFG_W'($urandom_range(1, 6)));
          write_reg(CFG_HEIGHT, CFG_W'($urandom_range(1, 2)));
          send_body(20, 1'b0);
        end
        6: begin                        // long receiver hold while bytes keep coming
          write_cfg(24, 6, 1'b0, pick_color());
          long_hold = 1'b1;
          send_image(40, 1'b0);
        end
        7: begin                        // sender pauses mid-image until drained
          write_cfg($urandom_range(8, 24), $urandom_range(3, 6), 1'b1, pick_color());
          send_header();
          send_body(6, 1'b0);
          wait_drained();
          send_body(30, 1'b0);
        end
        default: begin
          write_cfg($urandom_range(1, 24), $urandom_range(1, 6), 1'($urandom_range(0, 1)),
                    pick_color());
          n_img = $urandom_range(1, 3);
          repeat (n_img) send_image($urandom_range(4, 40), $urandom_range(0, 5) == 0);
        end
      endcase
      phase++;
    end

    // Drain everything, then let stray results settle.
    wait_drained();
    $display("covered %0d decoded bytes over %0d phases, %0d images completed",
             sb.bytes_used, phase, sb.images_done);
    $display("checked %0d results holding %0d pixels, %0d mismatches",
             sb.beats_seen, sb.pixels_seen, sb.errors);
    if (sb.errors == 0 && sb.beats_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
